// ===== design/assert_macros.svh =====
// assertion helpers shared by the pool manager modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define PFPM_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pool manager check failed");

// consequent must hold in the cycle of the antecedent
`define PFPM_CHECK_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pool manager check failed");

`endif

// ===== design/pfpm_pkg.sv =====
package pfpm_pkg;

  localparam int FRAMES   = 16;
  localparam int FRAME_W  = $clog2(FRAMES);
  localparam int FCNT_W   = FRAME_W + 1;
  localparam int PIN_BITS = 16;
  localparam int PAGE_W   = 31;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [2:0] {
    OP_NEW       = 3'd0,
    OP_FETCH     = 3'd1,
    OP_UNPIN     = 3'd2,
    OP_DELETE    = 3'd3,
    OP_FLUSH     = 3'd4,
    OP_FLUSH_ALL = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_WB     = 2'd1,
    KIND_RDIN   = 2'd2,
    KIND_CLR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTRES  = 2'd1,
    ST_NOFRAME = 2'd2,
    ST_PINNED  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIDE = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_TAKE,
    S_FREE_RD,
    S_VICT_RD,
    S_EVICT,
    S_CLR,
    S_RDIN,
    S_FLWB,
    S_FA_SCAN,
    S_FA_WB,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [PAGE_W-1:0] request_page;
    logic              dirty_mark;
  } in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         status_code;
    logic [FRAME_W-1:0] frame_index;
    logic [PAGE_W-1:0]  result_page;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic               rm_en;
    logic               ap_en;
    logic [FRAME_W-1:0] frame;
  } lru_cmd_t;

  typedef struct packed {
    logic               nonempty;
    logic [FRAME_W-1:0] head;
  } lru_stat_t;

endpackage

// ===== design/pfpm_ram.sv =====
module pfpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pfpm_lru.sv =====
`include "assert_macros.svh"

module pfpm_lru import pfpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lru_cmd_t  cmd,
  output lru_stat_t stat
);

  logic [FRAME_W-1:0] order_r   [FRAMES];
  logic [FRAME_W-1:0] order_nxt [FRAMES];
  logic [FCNT_W-1:0]  len_r, len_nxt;
  logic [FRAMES-1:0]  in_r, in_nxt;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int j = 0; j < FRAMES; j++) begin
      order_nxt[j] = order_r[j];
    end
    len_nxt = len_r;
    in_nxt  = in_r;
    if (cmd.rm_en && in_r[cmd.frame]) begin
      // close the gap left by the removed entry
      for (int j = 0; j < FRAMES - 1; j++) begin
        if ((FCNT_W'(j) < len_r) && (order_r[j] == cmd.frame)) begin
          seen = 1'b1;
        end
        if (seen) begin
          order_nxt[j] = order_r[j+1];
        end
      end
      len_nxt = len_r - FCNT_W'(1);
      in_nxt[cmd.frame] = 1'b0;
    end else if (cmd.ap_en && !in_r[cmd.frame] && (len_r < FCNT_W'(FRAMES))) begin
      order_nxt[len_r[FRAME_W-1:0]] = cmd.frame;
      len_nxt = len_r + FCNT_W'(1);
      in_nxt[cmd.frame] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      in_r  <= '0;
    end else begin
      len_r <= len_nxt;
      in_r  <= in_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < FRAMES; j++) begin
      order_r[j] <= order_nxt[j];
    end
  end

  assign stat.nonempty = (len_r != '0);
  assign stat.head     = order_r[0];

  `PFPM_CHECK(a_lru_len_range, len_r <= FCNT_W'(FRAMES))
  `PFPM_CHECK(a_lru_marks_match_len, $countones(in_r) == int'(len_r))

endmodule

// ===== design/page_frame_pool_manager_unit.sv =====
// Page frame pool manager: tracks 16 page frames (resident page, used mark,
// saturating pin count, dirty mark), a FIFO of free frames and an LRU list of
// unpinned frames, and runs new, fetch, unpin, delete, flush and flush_all one
// item at a time. Each item produces its write-back, clear-frame and read-in
// requests, if any (in that order), followed by one final status with
// last_result set. Resident pages live in a single-port-read page RAM, so a
// page lookup walks the frames one per cycle. Fetch, unpin, delete and flush
// first look the page up; a fetch miss then takes a frame from the free FIFO
// (S_TAKE, S_FREE_RD, S_VICT_RD, S_EVICT) or from the LRU list (S_TAKE,
// S_VICT_RD, S_EVICT), and deleting an unpinned page passes S_VICT_RD and
// S_EVICT; a write-back of the victim goes out in S_EVICT. new takes its
// frame the same way, or fails in S_TAKE when no frame is available.
// flush_all walks every frame and sends a write-back for each dirty one.
// Output stalls hold the result states. The free FIFO sits in a second
// RAM whose never-written entries read as their own index, so no clearing
// pass is needed after reset. page_offset writes reload the next allocated
// page number; configure only while the block is idle.
`include "assert_macros.svh"

module page_frame_pool_manager_unit import pfpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // sequencer state
  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic               mark_r, mark_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               hit_r, hit_nxt;
  logic               fail_r, fail_nxt;
  logic [FCNT_W-1:0]  ptr_r, ptr_nxt;
  logic [PAGE_W-1:0]  hold_r, hold_nxt;

  // pool state
  logic [CFG_W-1:0]    stride_r, stride_nxt;
  logic [PAGE_W-1:0]   next_page_r, next_page_nxt;
  logic [FRAME_W-1:0]  free_head_r, free_head_nxt;
  logic [FCNT_W-1:0]   free_cnt_r, free_cnt_nxt;
  logic [FRAMES-1:0]   fifo_wr_r, fifo_wr_nxt;
  logic [FRAMES-1:0]   used_r, used_nxt;
  logic [FRAMES-1:0]   dirty_r, dirty_nxt;
  logic [PIN_BITS-1:0] pin_r   [FRAMES];
  logic [PIN_BITS-1:0] pin_nxt [FRAMES];

  // result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic out_free;

  // memories
  logic               pg_we;
  logic [FRAME_W-1:0] pg_waddr, pg_raddr;
  logic [PAGE_W-1:0]  pg_wdata, pg_rdata;
  logic               ff_we;
  logic [FRAME_W-1:0] ff_waddr, ff_raddr;
  logic [FRAME_W-1:0] ff_wdata, ff_rdata;

  lru_cmd_t  lru_cmd;
  lru_stat_t lru_stat;

  // frame under test during a walk is one behind the walk pointer, as the page RAM read is registered
  logic [FRAME_W-1:0] prev;
  logic               scan_chk, ptr_end, any_free;
  logic [FRAME_W-1:0] sel;
  logic [FRAME_W-1:0] scan_addr;
  logic [FCNT_W:0]    tail_sum;
  logic [FRAME_W-1:0] tail;
  logic               fin_go;

  pfpm_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (pg_raddr),
    .rdata (pg_rdata)
  );

  pfpm_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_free_ram (
    .clk   (clk),
    .we    (ff_we),
    .waddr (ff_waddr),
    .wdata (ff_wdata),
    .raddr (ff_raddr),
    .rdata (ff_rdata)
  );

  pfpm_lru u_lru (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lru_cmd),
    .stat  (lru_stat)
  );

  function automatic out_t mk_out(kind_t k, status_t s, logic [FRAME_W-1:0] f,
                                  logic [PAGE_W-1:0] p, logic l);
    out_t o;
    o.result_kind = k;
    o.status_code = s;
    o.frame_index = f;
    o.result_page = p;
    o.last_result = l;
    return o;
  endfunction

  assign prev      = FRAME_W'(ptr_r - FCNT_W'(1));
  assign scan_chk  = (ptr_r != '0);
  assign ptr_end   = (ptr_r == FCNT_W'(FRAMES));
  assign scan_addr = ptr_end ? '0 : ptr_r[FRAME_W-1:0];
  assign sel       = ((state_r == S_SCAN) || (state_r == S_FA_SCAN)) ? prev : frame_r;
  assign out_free  = !out_valid_r || !out_stall;
  // free FIFO tail, wrapped to the frame count
  assign tail_sum  = (FCNT_W+1)'(free_head_r) + (FCNT_W+1)'(free_cnt_r);
  assign tail      = (tail_sum >= (FCNT_W+1)'(FRAMES)) ?
                     FRAME_W'(tail_sum - (FCNT_W+1)'(FRAMES)) : FRAME_W'(tail_sum);

  always_comb begin
    any_free = 1'b0;
    for (int f = 0; f < FRAMES; f++) begin
      if (pin_r[f] == '0) begin
        any_free = 1'b1;
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign fin_go   = (state_r == S_FIN) && out_free;

  always_comb begin
    logic [PIN_BITS-1:0] pin_sel;
    logic [PIN_BITS-1:0] pin_dec;
    pin_sel = pin_r[sel];
    pin_dec = '0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    page_nxt      = page_r;
    mark_nxt      = mark_r;
    frame_nxt     = frame_r;
    hit_nxt       = hit_r;
    fail_nxt      = fail_r;
    ptr_nxt       = ptr_r;
    hold_nxt      = hold_r;
    stride_nxt    = stride_r;
    next_page_nxt = next_page_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    fifo_wr_nxt   = fifo_wr_r;
    used_nxt      = used_r;
    dirty_nxt     = dirty_r;
    for (int f = 0; f < FRAMES; f++) begin
      pin_nxt[f] = pin_r[f];
    end
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pg_we    = 1'b0;
    pg_waddr = frame_r;
    pg_wdata = page_r;
    pg_raddr = frame_r;
    ff_we    = 1'b0;
    ff_waddr = tail;
    ff_wdata = frame_r;
    ff_raddr = free_head_r;
    lru_cmd  = '{rm_en: 1'b0, ap_en: 1'b0, frame: frame_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          page_nxt  = in_data.request_page;
          mark_nxt  = in_data.dirty_mark;
          hit_nxt   = 1'b0;
          fail_nxt  = 1'b0;
          ptr_nxt   = '0;
          frame_nxt = '0;
          unique case (in_data.operation)
            OP_NEW:                                  state_nxt = S_TAKE;
            OP_FETCH, OP_UNPIN, OP_DELETE, OP_FLUSH: state_nxt = S_SCAN;
            OP_FLUSH_ALL:                            state_nxt = S_FA_SCAN;
            default:                                 state_nxt = S_FIN;
          endcase
        end
      end

      // page lookup, lowest matching frame wins
      S_SCAN: begin
        pg_raddr = scan_addr;
        if (scan_chk && used_r[prev] && (pg_rdata == page_r)) begin
          hit_nxt   = 1'b1;
          frame_nxt = prev;
          if ((op_r == OP_DELETE) && (pin_sel == '0)) begin
            state_nxt = S_VICT_RD;
          end else if (op_r == OP_FLUSH) begin
            state_nxt = S_FLWB;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (ptr_end) begin
          state_nxt = (op_r == OP_FETCH) ? S_TAKE : S_FIN;
        end else begin
          ptr_nxt = ptr_r + FCNT_W'(1);
        end
      end

      // free FIFO first, then the least recently unpinned frame
      S_TAKE: begin
        if ((op_r == OP_NEW) && !any_free) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else if (free_cnt_r != '0) begin
          state_nxt = S_FREE_RD;
        end else if (lru_stat.nonempty) begin
          frame_nxt     = lru_stat.head;
          lru_cmd.rm_en = 1'b1;
          lru_cmd.frame = lru_stat.head;
          state_nxt     = S_VICT_RD;
        end else begin
          fail_nxt  = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_FREE_RD: begin
        // an entry never written holds its own frame number
        frame_nxt     = fifo_wr_r[free_head_r] ? ff_rdata : free_head_r;
        free_head_nxt = (free_head_r == FRAME_W'(FRAMES - 1)) ?
                        '0 : free_head_r + FRAME_W'(1);
        free_cnt_nxt  = free_cnt_r - FCNT_W'(1);
        state_nxt     = S_VICT_RD;
      end

      S_VICT_RD: begin
        state_nxt = S_EVICT;
      end

      S_EVICT: begin
        if (used_r[frame_r] && dirty_r[frame_r]) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = mk_out(KIND_WB, ST_OK, frame_r, pg_rdata, 1'b0);
            dirty_nxt[frame_r] = 1'b0;
            state_nxt = S_CLR;
          end
        end else begin
          state_nxt = S_CLR;
        end
      end

      S_CLR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(KIND_CLR, ST_OK, frame_r, '0, 1'b0);
          used_nxt[frame_r]  = 1'b0;
          dirty_nxt[frame_r] = 1'b0;
          state_nxt = (op_r == OP_FETCH) ? S_RDIN : S_FIN;
        end
      end

      S_RDIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(KIND_RDIN, ST_OK, frame_r, page_r, 1'b0);
          state_nxt = S_FIN;
        end
      end

      S_FLWB: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(KIND_WB, ST_OK, frame_r, page_r, 1'b0);
          dirty_nxt[frame_r] = 1'b0;
          state_nxt = S_FIN;
        end
      end

      // walk every frame, writing back the dirty ones
      S_FA_SCAN: begin
        pg_raddr = scan_addr;
        if (scan_chk && used_r[prev] && dirty_r[prev]) begin
          hold_nxt  = pg_rdata;
          frame_nxt = prev;
          state_nxt = S_FA_WB;
        end else if (ptr_end) begin
          state_nxt = S_FIN;
        end else begin
          ptr_nxt = ptr_r + FCNT_W'(1);
        end
      end

      S_FA_WB: begin
        pg_raddr = scan_addr;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_out(KIND_WB, ST_OK, frame_r, hold_r, 1'b0);
          dirty_nxt[frame_r] = 1'b0;
          state_nxt = S_FA_SCAN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          out_data_nxt  = mk_out(KIND_STATUS, ST_OK, '0, '0, 1'b1);
          unique case (op_r)
            OP_NEW: begin
              if (fail_r) begin
                out_data_nxt = mk_out(KIND_STATUS, ST_NOFRAME, '0, '0, 1'b1);
              end else begin
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, frame_r, next_page_r, 1'b1);
                pg_we    = 1'b1;
                pg_wdata = next_page_r;
                used_nxt[frame_r] = 1'b1;
                pin_nxt[frame_r]  = PIN_BITS'(1);
                next_page_nxt = PAGE_W'(next_page_r + PAGE_W'(stride_r));
              end
            end
            OP_FETCH: begin
              if (hit_r) begin
                if (pin_sel != '1) begin
                  pin_nxt[frame_r] = pin_sel + PIN_BITS'(1);
                end
                lru_cmd.rm_en = 1'b1;
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, frame_r, page_r, 1'b1);
              end else if (fail_r) begin
                out_data_nxt = mk_out(KIND_STATUS, ST_NOFRAME, '0, page_r, 1'b1);
              end else begin
                pg_we = 1'b1;
                used_nxt[frame_r] = 1'b1;
                pin_nxt[frame_r]  = PIN_BITS'(1);
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, frame_r, page_r, 1'b1);
              end
            end
            OP_UNPIN: begin
              if (!hit_r) begin
                out_data_nxt = mk_out(KIND_STATUS, ST_NOTRES, '0, page_r, 1'b1);
              end else begin
                pin_dec = (pin_sel == '0) ? '0 : pin_sel - PIN_BITS'(1);
                pin_nxt[frame_r] = pin_dec;
                if (mark_r) begin
                  dirty_nxt[frame_r] = 1'b1;
                end
                lru_cmd.ap_en = (pin_dec == '0);
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, frame_r, page_r, 1'b1);
              end
            end
            OP_DELETE: begin
              if (!hit_r) begin
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, '0, page_r, 1'b1);
              end else if (pin_sel != '0) begin
                out_data_nxt = mk_out(KIND_STATUS, ST_PINNED, frame_r, page_r, 1'b1);
              end else begin
                lru_cmd.rm_en = 1'b1;
                if (free_cnt_r < FCNT_W'(FRAMES)) begin
                  ff_we = 1'b1;
                  fifo_wr_nxt[tail] = 1'b1;
                  free_cnt_nxt = free_cnt_r + FCNT_W'(1);
                end
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, frame_r, page_r, 1'b1);
              end
            end
            OP_FLUSH: begin
              if (!hit_r) begin
                out_data_nxt = mk_out(KIND_STATUS, ST_NOTRES, '0, page_r, 1'b1);
              end else begin
                out_data_nxt = mk_out(KIND_STATUS, ST_OK, frame_r, page_r, 1'b1);
              end
            end
            default: begin
              out_data_nxt = mk_out(KIND_STATUS, ST_OK, '0, '0, 1'b1);
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRIDE: stride_nxt    = cfg_wdata;
        CFG_OFFSET: next_page_nxt = PAGE_W'(cfg_wdata);
        default:    stride_nxt    = stride_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stride_r    <= CFG_W'(1);
      next_page_r <= '0;
      free_head_r <= '0;
      free_cnt_r  <= FCNT_W'(FRAMES);
      fifo_wr_r   <= '0;
      used_r      <= '0;
      dirty_r     <= '0;
      for (int f = 0; f < FRAMES; f++) begin
        pin_r[f] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stride_r    <= stride_nxt;
      next_page_r <= next_page_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fifo_wr_r   <= fifo_wr_nxt;
      used_r      <= used_nxt;
      dirty_r     <= dirty_nxt;
      for (int f = 0; f < FRAMES; f++) begin
        pin_r[f] <= pin_nxt[f];
      end
    end
  end

  // item payload and result data
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    page_r     <= page_nxt;
    mark_r     <= mark_nxt;
    frame_r    <= frame_nxt;
    hit_r      <= hit_nxt;
    fail_r     <= fail_nxt;
    ptr_r      <= ptr_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PFPM_CHECK(a_free_cnt_range, free_cnt_r <= FCNT_W'(FRAMES))
  `PFPM_CHECK_IMP(a_idle_after_final, (state_r != S_IDLE) && (state_nxt == S_IDLE), fin_go)

endmodule

// ===== test/page_frame_pool_checker.sv =====
module page_frame_pool_checker import pfpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   errors,
  output int                   pending
);

  localparam logic [PIN_BITS-1:0] PIN_TOP = '1;
  localparam int EXP_DEPTH = 64;

  logic [CFG_W-1:0]    stride_q;
  logic [PAGE_W-1:0]   alloc_page;
  logic [PAGE_W-1:0]   fr_page [FRAMES];
  logic                fr_used [FRAMES];
  logic [PIN_BITS-1:0] fr_pins [FRAMES];
  logic                fr_dirty [FRAMES];
  logic [FRAME_W-1:0]  free_ring [FRAMES];
  int                  free_hd, free_cnt;
  logic [FRAME_W-1:0]  lru_list [FRAMES];
  int                  lru_cnt;
  logic                fr_in_lru [FRAMES];

  // expected results in order, as a ring
  out_t exp_buf [EXP_DEPTH];
  int   exp_wr, exp_rd;

  assign pending = exp_wr - exp_rd;

  function automatic void push_result(kind_t k, status_t s, int f, logic [PAGE_W-1:0] p,
                                      logic last);
    out_t r;
    r.result_kind = k;
    r.status_code = s;
    r.frame_index = FRAME_W'(f);
    r.result_page = p;
    r.last_result = last;
    exp_buf[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic int lookup(logic [PAGE_W-1:0] p);
    for (int f = 0; f < FRAMES; f++)
      if (fr_used[f] && fr_page[f] == p) return f;
    return -1;
  endfunction

  function automatic void lru_drop(int f);
    if (!fr_in_lru[f]) return;
    for (int i = 0; i < lru_cnt; i++) begin
      if (lru_list[i] == f) begin
        for (int j = i; j + 1 < lru_cnt; j++) lru_list[j] = lru_list[j+1];
        lru_cnt--;
        break;
      end
    end
    fr_in_lru[f] = 1'b0;
  endfunction

  // free fifo first, then the least recently unpinned frame
  function automatic int grab_frame();
    int f;
    if (free_cnt > 0) begin
      f = free_ring[free_hd];
      free_hd = (free_hd + 1) % FRAMES;
      free_cnt--;
      return f;
    end
    if (lru_cnt == 0) return -1;
    f = lru_list[0];
    lru_drop(f);
    return f;
  endfunction

  function automatic void evict_frame(int f);
    if (fr_used[f] && fr_dirty[f]) push_result(KIND_WB, ST_OK, f, fr_page[f], 1'b0);
    fr_dirty[f] = 1'b0;
    push_result(KIND_CLR, ST_OK, f, '0, 1'b0);
    fr_used[f] = 1'b0;
    fr_page[f] = '0;
  endfunction

  function automatic void predict_results(in_t it);
    int                h;
    logic              any_unpinned;
    logic [PAGE_W-1:0] pg;
    pg = it.request_page;
    case (it.operation)
      OP_NEW: begin
        any_unpinned = 1'b0;
        for (int f = 0; f < FRAMES; f++) if (fr_pins[f] == 0) any_unpinned = 1'b1;
        h = any_unpinned ? grab_frame() : -1;
        if (h < 0) begin
          push_result(KIND_STATUS, ST_NOFRAME, 0, '0, 1'b1);
        end else begin
          pg = alloc_page;
          alloc_page = alloc_page + PAGE_W'(stride_q);
          evict_frame(h);
          fr_page[h] = pg;
          fr_used[h] = 1'b1;
          lru_drop(h);
          fr_pins[h] = 1;
          push_result(KIND_STATUS, ST_OK, h, pg, 1'b1);
        end
      end
      OP_FETCH: begin
        h = lookup(pg);
        if (h >= 0) begin
          if (fr_pins[h] != PIN_TOP) fr_pins[h]++;
          lru_drop(h);
          push_result(KIND_STATUS, ST_OK, h, pg, 1'b1);
        end else begin
          h = grab_frame();
          if (h < 0) begin
            push_result(KIND_STATUS, ST_NOFRAME, 0, pg, 1'b1);
          end else begin
            evict_frame(h);
            fr_page[h] = pg;
            fr_used[h] = 1'b1;
            push_result(KIND_RDIN, ST_OK, h, pg, 1'b0);
            lru_drop(h);
            fr_pins[h] = 1;
            push_result(KIND_STATUS, ST_OK, h, pg, 1'b1);
          end
        end
      end
      OP_UNPIN: begin
        h = lookup(pg);
        if (h < 0) begin
          push_result(KIND_STATUS, ST_NOTRES, 0, pg, 1'b1);
        end else begin
          if (it.dirty_mark) fr_dirty[h] = 1'b1;
          if (fr_pins[h] != 0) fr_pins[h]--;
          if (fr_pins[h] == 0 && !fr_in_lru[h] && lru_cnt < FRAMES) begin
            lru_list[lru_cnt] = FRAME_W'(h);
            lru_cnt++;
            fr_in_lru[h] = 1'b1;
          end
          push_result(KIND_STATUS, ST_OK, h, pg, 1'b1);
        end
      end
      OP_DELETE: begin
        h = lookup(pg);
        if (h < 0) begin
          push_result(KIND_STATUS, ST_OK, 0, pg, 1'b1);
        end else if (fr_pins[h] != 0) begin
          push_result(KIND_STATUS, ST_PINNED, h, pg, 1'b1);
        end else begin
          lru_drop(h);
          evict_frame(h);
          fr_pins[h] = 0;
          if (free_cnt < FRAMES) begin
            free_ring[(free_hd + free_cnt) % FRAMES] = FRAME_W'(h);
            free_cnt++;
          end
          push_result(KIND_STATUS, ST_OK, h, pg, 1'b1);
        end
      end
      OP_FLUSH: begin
        h = lookup(pg);
        if (h < 0) begin
          push_result(KIND_STATUS, ST_NOTRES, 0, pg, 1'b1);
        end else begin
          push_result(KIND_WB, ST_OK, h, pg, 1'b0);
          fr_dirty[h] = 1'b0;
          push_result(KIND_STATUS, ST_OK, h, pg, 1'b1);
        end
      end
      OP_FLUSH_ALL: begin
        for (int f = 0; f < FRAMES; f++) begin
          if (fr_used[f] && fr_dirty[f]) begin
            push_result(KIND_WB, ST_OK, f, fr_page[f], 1'b0);
            fr_dirty[f] = 1'b0;
          end
        end
        push_result(KIND_STATUS, ST_OK, 0, '0, 1'b1);
      end
      default: push_result(KIND_STATUS, ST_OK, 0, '0, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      stride_q   <= 1;
      alloc_page  = '0;
      for (int f = 0; f < FRAMES; f++) begin
        fr_page[f]   = '0;
        fr_used[f]   = 1'b0;
        fr_pins[f]   = '0;
        fr_dirty[f]  = 1'b0;
        free_ring[f] = FRAME_W'(f);
        lru_list[f]  = '0;
        fr_in_lru[f] = 1'b0;
      end
      free_hd  = 0;
      free_cnt = FRAMES;
      lru_cnt  = 0;
      exp_wr   = 0;
      exp_rd   = 0;
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STRIDE) stride_q <= cfg_wdata;
        else alloc_page = PAGE_W'(cfg_wdata);
      end
      if (in_valid && !in_stall) predict_results(in_data);
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          $display("%0t: unexpected result, expected none actual %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          exp_r = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (exp_r !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/page_frame_pool_manager_unit_tb.sv =====
module page_frame_pool_manager_unit_tb;
  import pfpm_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors;
  int                   pending;

  // idle percentages per side, changed between phases
  int send_idle_pct;
  int recv_stall_pct;
  // allocation settings the stimulus aims its page numbers at
  int cur_stride;
  int cur_offset;

  always #4 clk = ~clk;

  page_frame_pool_manager_unit u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  page_frame_pool_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // one transfer on the input channel; valid stays high into the next call
  task automatic send(logic [2:0] op, logic [PAGE_W-1:0] pg, logic mark);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, request_page: pg, dirty_mark: mark};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding result, plus a little slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write enable stays high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
  endtask

  task automatic set_alloc(int stride, int offset);
    write_reg(CFG_STRIDE, stride);
    write_reg(CFG_OFFSET, offset);
    cfg_we <= 1'b0;
    cur_stride = stride;
    cur_offset = offset;
  endtask

  // mostly pages that are likely resident, sometimes anything
  function automatic logic [PAGE_W-1:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 45) return PAGE_W'(cur_offset + cur_stride * $urandom_range(0, 20));
    if (r < 85) return PAGE_W'($urandom_range(0, 24));
    if (r < 92) return {PAGE_W{1'b1}};
    return PAGE_W'($urandom());
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 16) return OP_NEW;
    if (r < 40) return OP_FETCH;
    if (r < 72) return OP_UNPIN;
    if (r < 84) return OP_DELETE;
    if (r < 92) return OP_FLUSH;
    if (r < 97) return OP_FLUSH_ALL;
    return 3'($urandom_range(6, 7));
  endfunction

  initial begin
    int strides[4];
    int offsets[4];
    int snd[4];
    int rcv[4];
    strides = '{255, 0, 3, 1};
    offsets = '{254, 7, 1, 0};
    snd = '{0, 65, 0, 36};
    rcv = '{0, 0, 65, 36};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_stride = 1;
    cur_offset = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_STRIDE;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, stride 1 from page 0
    send(OP_FETCH, 3, 1'b0);                     // read-in into a free frame
    send(OP_FETCH, 3, 1'b0);                     // hit, pin goes to two
    send(OP_UNPIN, 3, 1'b1);                     // still pinned, marks dirty
    send(OP_FLUSH, 3, 1'b0);                     // write-back of a dirty page
    send(OP_FLUSH, 3, 1'b0);                     // flush of a clean page
    send(OP_DELETE, 3, 1'b0);                    // delete while pinned
    send(OP_UNPIN, 3, 1'b1);                     // drops to zero, enters lru
    send(OP_UNPIN, 3, 1'b0);                     // unpin of an unpinned page
    send(OP_DELETE, 3, 1'b0);                    // delete of an unpinned page
    send(OP_DELETE, 3, 1'b0);                    // delete of an absent page
    send(OP_UNPIN, {PAGE_W{1'b1}}, 1'b1);        // unpin of a missing page
    send(OP_FLUSH, 0, 1'b0);                     // flush of a missing page
    send(OP_FETCH, 2, 1'b0);
    // new runs through page 2 again: the same page sits in two frames
    for (int i = 0; i < 16; i++) send(OP_NEW, '1, 1'b1);
    send(OP_NEW, 0, 1'b0);                       // every frame pinned
    send(OP_FETCH, {PAGE_W{1'b1}}, 1'b0);        // no frame for a fetch
    send(OP_UNPIN, 2, 1'b1);                     // lowest matching frame
    send(OP_UNPIN, 5, 1'b1);
    send(OP_FLUSH_ALL, 0, 1'b0);
    send(OP_UNPIN, 7, 1'b1);
    send(OP_FETCH, 0, 1'b0);                     // hit, page 0 came from the first new
    send(3'd6, '1, 1'b1);
    send(3'd7, 0, 1'b0);
    // sender holds off until every result is back
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_alloc(strides[ph], offsets[ph]);
      send_idle_pct  = snd[ph];
      recv_stall_pct = rcv[ph];
      for (int i = 0; i < 72; i++) send(pick_op(), pick_page(), 1'($urandom_range(1)));
      // a stretch without idling inside each phase
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 8; i++) send(pick_op(), pick_page(), 1'($urandom_range(1)));
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("page_frame_pool_manager_unit_tb: done, clean");
    end else begin
      $display("page_frame_pool_manager_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("page_frame_pool_manager_unit_tb: done, errors");
    $finish;
  end

endmodule
